### rtl/core/bmtc_pkg.sv
// shared types and constants for the bit matrix transitive closure block
`default_nettype none
package bmtc_pkg;

  localparam int ROW_W     = 32;
  localparam int SIZE_W    = 6;
  localparam int OUT_IDX_W = 5;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 6'd32;

  // register index codes
  localparam logic REG_MATRIX_SIZE = 1'b0;

  typedef struct packed {
    logic                 load;
    logic                 close;
    logic                 emit;
    logic                 last;
    logic                 flush;
    logic [OUT_IDX_W-1:0] idx;
  } cmd_t;

  typedef struct packed {
    logic slot_free;
  } status_t;

endpackage
`default_nettype wire

### rtl/core/bmtc_datapath.sv
// row storage, column pass logic and output register
`default_nettype none
module bmtc_datapath #(
  parameter int ROWS = 32
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire bmtc_pkg::cmd_t                     cmd,
  input  wire logic [bmtc_pkg::SIZE_W-1:0]        eff_size,
  input  wire logic [bmtc_pkg::ROW_W-1:0]         row_bits,
  input  wire logic                               out_ready,
  output bmtc_pkg::status_t                       status,
  output logic                                    out_valid,
  output logic [bmtc_pkg::OUT_IDX_W-1:0]          out_row_index,
  output logic [bmtc_pkg::ROW_W-1:0]              out_row_bits,
  output logic                                    last_row
);

  localparam int RIDX_W = $clog2(ROWS);

  logic [bmtc_pkg::ROW_W-1:0] rows [ROWS];
  logic [bmtc_pkg::ROW_W-1:0] row_sel;
  logic [bmtc_pkg::ROW_W-1:0] col_mask;
  logic [RIDX_W-1:0]          ridx;

  assign ridx    = cmd.idx[RIDX_W-1:0];
  assign row_sel = rows[ridx];

  always_comb begin
    for (int k = 0; k < bmtc_pkg::ROW_W; k++) begin
      col_mask[k] = (bmtc_pkg::SIZE_W'(k) < eff_size);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rows[ridx] <= row_bits & col_mask;
    end else if (cmd.close) begin
      for (int i = 0; i < ROWS; i++) begin
        if (rows[i][cmd.idx]) begin
          rows[i] <= rows[i] | row_sel;
        end
      end
    end
  end

  assign status.slot_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.flush) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_row_index <= cmd.idx;
      out_row_bits  <= row_sel;
      last_row      <= cmd.last;
    end
  end

endmodule
`default_nettype wire

### rtl/core/bmtc_controller.sv
// load, close and emit sequencer
`default_nettype none
module bmtc_controller #(
  parameter int ROWS = 32
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_we,
  input  wire logic [bmtc_pkg::SIZE_W-1:0] eff_size,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire bmtc_pkg::status_t           status,
  output bmtc_pkg::cmd_t                   cmd
);

  localparam int RIDX_W = $clog2(ROWS);

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_CLOSE,
    ST_EMIT
  } state_t;

  state_t            state;
  logic [RIDX_W-1:0] cnt;
  logic              at_end;

  assign at_end   = (bmtc_pkg::SIZE_W'(cnt) == eff_size - bmtc_pkg::SIZE_W'(1));
  assign in_ready = (state == ST_LOAD);

  always_comb begin
    cmd.load  = (state == ST_LOAD) && in_valid;
    cmd.close = (state == ST_CLOSE);
    cmd.emit  = (state == ST_EMIT) && status.slot_free;
    cmd.last  = at_end;
    cmd.flush = cfg_we;
    cmd.idx   = bmtc_pkg::OUT_IDX_W'(cnt);
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      state <= ST_LOAD;
      cnt   <= '0;
    end else begin
      unique case (state)
        ST_LOAD: begin
          if (in_valid) begin
            if (at_end) begin
              state <= ST_CLOSE;
              cnt   <= '0;
            end else begin
              cnt <= cnt + RIDX_W'(1);
            end
          end
        end
        ST_CLOSE: begin
          if (at_end) begin
            state <= ST_EMIT;
            cnt   <= '0;
          end else begin
            cnt <= cnt + RIDX_W'(1);
          end
        end
        ST_EMIT: begin
          if (status.slot_free) begin
            if (at_end) begin
              state <= ST_LOAD;
              cnt   <= '0;
            end else begin
              cnt <= cnt + RIDX_W'(1);
            end
          end
        end
        default: begin
          state <= ST_LOAD;
          cnt   <= '0;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

### rtl/core/bit_matrix_transitive_closure.sv
// top level of the bit matrix transitive closure block
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+------------------------------------------
//  in       | in_valid / in_ready        | row_bits
//  out      | out_valid / out_ready      | out_row_index, out_row_bits, last_row
//  cfg      | apb psel/penable/pwrite    | paddr, pwdata, prdata (matrix_size @ 0x0)
//
// a matrix of n rows is loaded one row at a time, closed with n column passes and emitted one row at a time
// each column pass ors the selected row into every row with that column bit set
// the last row beat starts the closure, no input is taken until the last row is emitted
// emit stalls while the output register is held by out_ready low
// reset returns to loading with matrix_size 32, a matrix_size write restarts loading
`default_nettype none
module bit_matrix_transitive_closure #(
  parameter int MAX_ELEMENTS = 32
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [2:0]                     paddr,
  input  wire logic [31:0]                    pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [bmtc_pkg::ROW_W-1:0]     row_bits,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [bmtc_pkg::OUT_IDX_W-1:0]      out_row_index,
  output logic [bmtc_pkg::ROW_W-1:0]          out_row_bits,
  output logic                                last_row
);

  localparam int ROWS = (MAX_ELEMENTS < bmtc_pkg::ROW_W) ? MAX_ELEMENTS : bmtc_pkg::ROW_W;
  localparam logic [bmtc_pkg::SIZE_W-1:0] SIZE_LIM = bmtc_pkg::SIZE_W'(ROWS);

  logic [bmtc_pkg::SIZE_W-1:0] matrix_size;
  logic [bmtc_pkg::SIZE_W-1:0] eff_size;
  logic                        cfg_we;
  bmtc_pkg::cmd_t              cmd;
  bmtc_pkg::status_t           status;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == bmtc_pkg::REG_MATRIX_SIZE);

  always_ff @(posedge clk) begin
    if (rst) begin
      matrix_size <= bmtc_pkg::SIZE_RESET;
    end else if (cfg_we) begin
      matrix_size <= pwdata[bmtc_pkg::SIZE_W-1:0];
    end
  end

  always_comb begin
    if (paddr[2] == bmtc_pkg::REG_MATRIX_SIZE) begin
      prdata = 32'(matrix_size);
    end else begin
      prdata = '0;
    end
  end

  always_comb begin
    priority if (matrix_size == '0) begin
      eff_size = bmtc_pkg::SIZE_W'(1);
    end else if (matrix_size > SIZE_LIM) begin
      eff_size = SIZE_LIM;
    end else begin
      eff_size = matrix_size;
    end
  end

  bmtc_controller #(
    .ROWS (ROWS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .eff_size (eff_size),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  bmtc_datapath #(
    .ROWS (ROWS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .eff_size      (eff_size),
    .row_bits      (row_bits),
    .out_ready     (out_ready),
    .status        (status),
    .out_valid     (out_valid),
    .out_row_index (out_row_index),
    .out_row_bits  (out_row_bits),
    .last_row      (last_row)
  );

endmodule
`default_nettype wire

### rtl/core/bmtc_monitor.sv
// port level assertions for the bit matrix transitive closure block
`default_nettype none
module bmtc_monitor (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           psel,
  input wire logic                           penable,
  input wire logic                           pwrite,
  input wire logic                           in_ready,
  input wire logic                           out_valid,
  input wire logic                           out_ready,
  input wire logic [bmtc_pkg::OUT_IDX_W-1:0] out_row_index,
  input wire logic [bmtc_pkg::ROW_W-1:0]     out_row_bits,
  input wire logic                           last_row
);

  logic cfg_wr;
  assign cfg_wr = psel && penable && pwrite;

  a_reset_state: assert property (@(posedge clk)
    rst |=> (!out_valid && in_ready))
    else $error("block not idle after reset");

  a_load_only_after_last: assert property (@(posedge clk) disable iff (rst)
    (in_ready && out_valid) |-> last_row)
    else $error("loading while a non-final row is pending");

  // a non-final beat is followed at once by the next row of the burst
  a_burst_in_order: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !last_row && !cfg_wr) |=>
      (out_valid &&
       (out_row_index == bmtc_pkg::OUT_IDX_W'($past(out_row_index) + 1'b1))))
    else $error("row burst out of order");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready && !cfg_wr) |=>
      (out_valid && $stable(out_row_bits) && $stable(out_row_index) && $stable(last_row)))
    else $error("stalled output beat changed");

endmodule

bind bit_matrix_transitive_closure bmtc_monitor u_bmtc_monitor (.*);
`default_nettype wire
